// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// expression never true
`define ASSERT_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error("assertion failed");

`endif

// ===== src/frsq_pkg.sv =====
// ----------------------------------------------------------------------------
// frsq_pkg
// constants and helpers for the reciprocal square root pipeline
// ----------------------------------------------------------------------------
package frsq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Latency = 16;

  localparam logic [31:0] GuessBase = 32'h5F3759DF;
  localparam logic [31:0] HalfBits = 32'h3F000000;
  localparam logic [31:0] OneHalfBits = 32'h3FC00000;
  localparam logic [31:0] CanonNan = 32'h7FC00000;
  localparam logic [31:0] PosInf = 32'h7F800000;

  function automatic logic [31:0] round_pack(input logic sgn, input logic [9:0] ebase,
                                             input logic [23:0] m, input logic g,
                                             input logic st);
    logic inc;
    logic [24:0] mr;
    logic [33:0] r;
    logic [31:0] o;
    inc = g & (st | m[0]);
    mr = {1'b0, m} + {24'b0, inc};
    r = {1'b0, ebase, 23'b0} + {9'b0, mr};
    if (r >= 34'h07F800000) begin
      o = {sgn, PosInf[30:0]};
    end else begin
      o = {sgn, r[30:0]};
    end
    return o;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 0; i < 48; i++) begin
      if (!found && v[47 - i]) begin
        n = 6'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic found;
    n = 5'd28;
    found = 1'b0;
    for (int i = 0; i < 28; i++) begin
      if (!found && v[27 - i]) begin
        n = 5'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== src/frsq_fmul.sv =====
// ----------------------------------------------------------------------------
// frsq_fmul
// three stage binary32 multiplier, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module frsq_fmul #(
  parameter int unsigned AuxW = frsq_pkg::WordW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  input  logic [AuxW-1:0] aux_in,
  output logic            out_valid,
  output logic [31:0]     res,
  output logic [AuxW-1:0] aux_out
);

  logic [7:0] ea, eb;
  logic inf_a, inf_b, zero_a, zero_b, nan_c;
  logic [23:0] ma, mb;
  logic [9:0] esum_c;

  assign ea = a[30:23];
  assign eb = b[30:23];
  assign inf_a = (ea == 8'hFF) && (a[22:0] == 23'b0);
  assign inf_b = (eb == 8'hFF) && (b[22:0] == 23'b0);
  assign zero_a = (ea == 8'h00) && (a[22:0] == 23'b0);
  assign zero_b = (eb == 8'h00) && (b[22:0] == 23'b0);
  assign nan_c = ((ea == 8'hFF) && (a[22:0] != 23'b0)) || ((eb == 8'hFF) && (b[22:0] != 23'b0))
                 || (inf_a && zero_b) || (inf_b && zero_a);
  assign ma = {ea != 8'h00, a[22:0]};
  assign mb = {eb != 8'h00, b[22:0]};
  assign esum_c = {2'b0, (ea == 8'h00) ? 8'd1 : ea} + {2'b0, (eb == 8'h00) ? 8'd1 : eb};

  // stage 1: product
  logic v1, sgn1, nan1, inf1;
  logic [47:0] p1;
  logic [9:0] esum1;
  logic [AuxW-1:0] aux1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    p1 <= ma * mb;
    esum1 <= esum_c;
    sgn1 <= a[31] ^ b[31];
    nan1 <= nan_c;
    inf1 <= inf_a | inf_b;
    aux1 <= aux_in;
  end

  // stage 2: normalize
  logic [5:0] lz, sh;
  logic [47:0] pn, shifted;
  logic signed [10:0] e2;
  logic [9:0] ebase_c;
  logic lost;

  always_comb begin
    lz = frsq_pkg::lzc48(p1);
    pn = p1 << lz;
    e2 = $signed({1'b0, esum1}) - 11'sd126 - $signed({5'b0, lz});
    if (e2 >= 11'sd1) begin
      ebase_c = e2[9:0] - 10'd1;
      sh = 6'd0;
    end else begin
      ebase_c = 10'd0;
      sh = (e2 < -11'sd47) ? 6'd48 : 6'(11'sd1 - e2);
    end
    shifted = pn >> sh;
    lost = (pn & ~({48{1'b1}} << sh)) != 48'b0;
  end

  logic v2, sgn2, nan2, inf2, zero2, g2, st2;
  logic [23:0] m2;
  logic [9:0] ebase2;
  logic [AuxW-1:0] aux2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m2 <= shifted[47:24];
    g2 <= shifted[23];
    st2 <= (shifted[22:0] != 23'b0) | lost;
    ebase2 <= ebase_c;
    sgn2 <= sgn1;
    nan2 <= nan1;
    inf2 <= inf1;
    zero2 <= (p1 == 48'b0);
    aux2 <= aux1;
  end

  // stage 3: round and pack
  logic [31:0] res_c;

  always_comb begin
    if (nan2) begin
      res_c = frsq_pkg::CanonNan;
    end else if (inf2) begin
      res_c = {sgn2, frsq_pkg::PosInf[30:0]};
    end else if (zero2) begin
      res_c = {sgn2, 31'b0};
    end else begin
      res_c = frsq_pkg::round_pack(sgn2, ebase2, m2, g2, st2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    res <= res_c;
    aux_out <= aux2;
  end

endmodule

// ===== src/frsq_fadd.sv =====
// ----------------------------------------------------------------------------
// frsq_fadd
// three stage binary32 adder, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module frsq_fadd #(
  parameter int unsigned AuxW = frsq_pkg::WordW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  input  logic [AuxW-1:0] aux_in,
  output logic            out_valid,
  output logic [31:0]     res,
  output logic [AuxW-1:0] aux_out
);

  logic inf_a, inf_b, nan_c, swap;
  logic [31:0] lg, sm;
  logic [7:0] el, es, d;
  logic [4:0] shd;
  logic [26:0] msx, aligned;
  logic lost;

  always_comb begin
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
    nan_c = ((a[30:23] == 8'hFF) && (a[22:0] != 23'b0))
            || ((b[30:23] == 8'hFF) && (b[22:0] != 23'b0))
            || (inf_a && inf_b && (a[31] != b[31]));
    swap = b[30:0] > a[30:0];
    lg = swap ? b : a;
    sm = swap ? a : b;
    el = (lg[30:23] == 8'h00) ? 8'd1 : lg[30:23];
    es = (sm[30:23] == 8'h00) ? 8'd1 : sm[30:23];
    d = el - es;
    shd = (d > 8'd27) ? 5'd27 : d[4:0];
    msx = {sm[30:23] != 8'h00, sm[22:0], 3'b0};
    aligned = msx >> shd;
    lost = (msx & ~({27{1'b1}} << shd)) != 27'b0;
  end

  // stage 1: align
  logic v1, sub1, sl1, zsgn1, nan1, inf1, isgn1;
  logic [26:0] ml1, ms1;
  logic [7:0] el1;
  logic [AuxW-1:0] aux1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ml1 <= {lg[30:23] != 8'h00, lg[22:0], 3'b0};
    ms1 <= {aligned[26:1], aligned[0] | lost};
    el1 <= el;
    sub1 <= a[31] != b[31];
    sl1 <= lg[31];
    zsgn1 <= a[31] & b[31];
    nan1 <= nan_c;
    inf1 <= inf_a | inf_b;
    isgn1 <= inf_a ? a[31] : b[31];
    aux1 <= aux_in;
  end

  // stage 2: add and normalize
  logic [27:0] s, n;
  logic [4:0] lz, shl;

  always_comb begin
    s = sub1 ? ({1'b0, ml1} - {1'b0, ms1}) : ({1'b0, ml1} + {1'b0, ms1});
    lz = frsq_pkg::lzc28(s);
    shl = ({3'b0, lz} <= el1) ? lz : el1[4:0];
    n = s << shl;
  end

  logic v2, sgn2, nan2, inf2, isgn2, zero2, g2, st2;
  logic [23:0] m2;
  logic [9:0] ebase2;
  logic [AuxW-1:0] aux2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m2 <= n[27:4];
    g2 <= n[3];
    st2 <= n[2:0] != 3'b0;
    ebase2 <= {2'b0, el1} - {5'b0, shl};
    zero2 <= s == 28'b0;
    sgn2 <= (s == 28'b0) ? zsgn1 : sl1;
    nan2 <= nan1;
    inf2 <= inf1;
    isgn2 <= isgn1;
    aux2 <= aux1;
  end

  // stage 3: round and pack
  logic [31:0] res_c;

  always_comb begin
    if (nan2) begin
      res_c = frsq_pkg::CanonNan;
    end else if (inf2) begin
      res_c = {isgn2, frsq_pkg::PosInf[30:0]};
    end else if (zero2) begin
      res_c = {sgn2, 31'b0};
    end else begin
      res_c = frsq_pkg::round_pack(sgn2, ebase2, m2, g2, st2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    res <= res_c;
    aux_out <= aux2;
  end

endmodule

// ===== src/fast_inverse_square_root.sv =====
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// magic constant first guess and one newton step on binary32 bit patterns
// ----------------------------------------------------------------------------
// channel   dir   handshake         payload
// request   in    start, busy       value_bits
// result    out   done              recip_root_bits
//
// one request per cycle
// each request passes through five three-stage float units in series plus an output register
// busy is always low: the pipeline never stalls
// rst is synchronous and clears every valid bit; data registers are not reset
// the receiver cannot stall, each result shows for one cycle with done
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fast_inverse_square_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_bits,
  output logic        done,
  output logic [31:0] recip_root_bits
);

  localparam int unsigned W = frsq_pkg::WordW;

  logic [31:0] guess;
  logic h_v, t1_v, t2_v, c_v, r_v;
  logic [31:0] h_res, t1_res, t2_res, c_res, r_res;
  logic [W-1:0] h_aux, t1_aux, t2_aux, c_aux;

  assign busy = 1'b0;
  assign guess = frsq_pkg::GuessBase - {1'b0, value_bits[31:1]};

  frsq_fmul #(.AuxW(W)) u_half (
    .clk(clk), .rst(rst), .in_valid(start & ~busy), .a(value_bits), .b(frsq_pkg::HalfBits),
    .aux_in(guess), .out_valid(h_v), .res(h_res), .aux_out(h_aux)
  );

  frsq_fmul #(.AuxW(W)) u_t1 (
    .clk(clk), .rst(rst), .in_valid(h_v), .a(h_res), .b(h_aux),
    .aux_in(h_aux), .out_valid(t1_v), .res(t1_res), .aux_out(t1_aux)
  );

  frsq_fmul #(.AuxW(W)) u_t2 (
    .clk(clk), .rst(rst), .in_valid(t1_v), .a(t1_res), .b(t1_aux),
    .aux_in(t1_aux), .out_valid(t2_v), .res(t2_res), .aux_out(t2_aux)
  );

  frsq_fadd #(.AuxW(W)) u_corr (
    .clk(clk), .rst(rst), .in_valid(t2_v), .a(frsq_pkg::OneHalfBits),
    .b({~t2_res[31], t2_res[30:0]}),
    .aux_in(t2_aux), .out_valid(c_v), .res(c_res), .aux_out(c_aux)
  );

  frsq_fmul #(.AuxW(1)) u_res (
    .clk(clk), .rst(rst), .in_valid(c_v), .a(c_aux), .b(c_res),
    .aux_in(1'b0), .out_valid(r_v), .res(r_res), .aux_out()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_v;
    end
    recip_root_bits <= r_res;
  end

  `ASSERT_IMPLIES(a_latency, clk, rst, done, $past(start, frsq_pkg::Latency))
  `ASSERT_NEVER(a_no_busy, clk, rst, busy)
  `ASSERT_IMPLIES(a_nan_canon, clk, rst,
                  done && (recip_root_bits[30:23] == 8'hFF) && (recip_root_bits[22:0] != 23'b0),
                  recip_root_bits == frsq_pkg::CanonNan)

endmodule
